>>> rtl/bam_lls_pkg.sv
// shared types and constants of the bam led layer scanner
package bam_lls_pkg;

	// fixed field widths
	localparam int WORD_W    = 24;
	localparam int DWELL_W   = 15;
	localparam int ROW_W     = 4;
	localparam int COL_W     = 4;
	localparam int MAX_SHOWN = 8;

	// function codes of an input word
	localparam logic [1:0] FUNC_TICK  = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_SWAP  = 2'd2;

	// highest bit plane, where a frame scan starts
	localparam logic [2:0] PLANE_TOP = 3'd7;

	// input word
	typedef struct packed {
		logic [1:0]        func;
		logic [5:0]        pixel_address;
		logic [WORD_W-1:0] pixel_color;
	} in_word_t;

	// result word
	typedef struct packed {
		logic              slot_start;
		logic [WORD_W-1:0] shift_word;
		logic [2:0]        active_layer;
		logic [2:0]        bit_plane;
	} out_word_t;

	// work for the back end
	typedef enum logic [1:0] {
		OP_NOP,
		OP_WRITE,
		OP_SHOW
	} op_t;

	// classified command between front and back end
	typedef struct packed {
		op_t               op;
		logic              bank;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [WORD_W-1:0] color;
		logic [2:0]        layer;
		logic [2:0]        plane;
	} cmd_t;

endpackage

>>> rtl/bam_led_layer_scanner_top.sv
// bam led layer scanner: top level joining front end, queue and back end
// an accepted input word passes a queue entry, the command stage and the output register
// throughput: one input word and one result word per cycle while out_ready stays high,
// set by the queue pop and the single row read of the frame store rams
// reset: asynchronous, clears scan position, timer, bank select and the
// per-entry written flags at once, so the store reads as zero with no clearing pass
module bam_led_layer_scanner_top #(
	parameter int LAYER_COUNT    = 8,
	parameter int LEDS_PER_LAYER = 8,
	parameter int PLANE_COUNT    = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bam_lls_pkg::in_word_t  in_word,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bam_lls_pkg::out_word_t out_word
);

	logic              push_valid;
	logic              push_ready;
	bam_lls_pkg::cmd_t push_cmd;
	logic              pop_valid;
	logic              pop_ready;
	bam_lls_pkg::cmd_t pop_cmd;

	// input classification and scan timing
	bam_lls_front #(
		.LAYER_COUNT    (LAYER_COUNT),
		.LEDS_PER_LAYER (LEDS_PER_LAYER),
		.PLANE_COUNT    (PLANE_COUNT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_word     (in_word),
		.push_valid  (push_valid),
		.push_ready  (push_ready),
		.push_cmd    (push_cmd)
	);

	// decoupling queue
	bam_lls_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_cmd    (pop_cmd)
	);

	// frame store and word build
	bam_lls_back #(
		.LAYER_COUNT    (LAYER_COUNT),
		.LEDS_PER_LAYER (LEDS_PER_LAYER)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word)
	);

endmodule

>>> rtl/bam_lls_ram.sv
// generic single write port ram with registered read
module bam_lls_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/bam_lls_queue.sv
// two entry command queue between front and back end
module bam_lls_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  bam_lls_pkg::cmd_t  push_cmd,
	output logic               pop_valid,
	input  logic               pop_ready,
	output bam_lls_pkg::cmd_t  pop_cmd
);

	bam_lls_pkg::cmd_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              push;
	logic              pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

>>> rtl/bam_lls_front.sv
// front end: accepts input words, keeps the scan position and slot timer
module bam_lls_front #(
	parameter int LAYER_COUNT    = 8,
	parameter int LEDS_PER_LAYER = 8,
	parameter int PLANE_COUNT    = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [7:0]             cfg_wr_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  bam_lls_pkg::in_word_t  in_word,
	output logic                   push_valid,
	input  logic                   push_ready,
	output bam_lls_pkg::cmd_t      push_cmd
);

	localparam int         LAYER_W    = $clog2(LAYER_COUNT);
	localparam int         BANK_WORDS = LAYER_COUNT * LEDS_PER_LAYER;
	localparam logic [2:0] LOW_PLANE  = 3'(8 - PLANE_COUNT);
	localparam logic [LAYER_W-1:0] LAST_LAYER = LAYER_W'(LAYER_COUNT - 1);

	logic [7:0]                       tick_scale_q;
	logic                             front_q;
	logic [LAYER_W-1:0]               layer_q;
	logic [2:0]                       plane_q;
	logic [bam_lls_pkg::DWELL_W-1:0]  dwell_q;

	logic                             front_d;
	logic [LAYER_W-1:0]               layer_d;
	logic [2:0]                       plane_d;
	logic [bam_lls_pkg::DWELL_W-1:0]  dwell_d;
	logic [bam_lls_pkg::DWELL_W-1:0]  dwell_cur;
	logic [bam_lls_pkg::DWELL_W-1:0]  dwell_load;
	logic [7:0]                       scale;
	logic [2:0]                       shift;
	logic                             addr_ok;
	logic                             accept;
	logic [bam_lls_pkg::ROW_W-1:0]    wr_row;
	logic [bam_lls_pkg::COL_W-1:0]    wr_col;
	bam_lls_pkg::cmd_t                cmd;

	assign in_ready   = push_ready;
	assign accept     = in_valid && in_ready;
	assign push_valid = in_valid;
	assign push_cmd   = cmd;

	// slot length from scale and plane weight
	assign scale      = (tick_scale_q == 8'd0) ? 8'd1 : tick_scale_q;
	assign shift      = plane_q - LOW_PLANE;
	assign dwell_load = bam_lls_pkg::DWELL_W'({7'd0, scale} << shift);
	assign addr_ok    = ({26'd0, in_word.pixel_address} < 32'(BANK_WORDS));

	// split a write address into layer row and led column
	always_comb begin
		wr_row = '0;
		wr_col = '0;
		for (int r = 0; r < LAYER_COUNT; r++) begin
			if ({2'd0, in_word.pixel_address} >= 8'(r * LEDS_PER_LAYER)) begin
				wr_row = bam_lls_pkg::ROW_W'(r);
				wr_col = bam_lls_pkg::COL_W'({2'd0, in_word.pixel_address}
					- 8'(r * LEDS_PER_LAYER));
			end
		end
	end

	// classify the word and step the scan
	always_comb begin
		front_d   = front_q;
		layer_d   = layer_q;
		plane_d   = plane_q;
		dwell_d   = dwell_q;
		dwell_cur = dwell_q;
		cmd.op    = bam_lls_pkg::OP_NOP;
		cmd.bank  = front_q;
		cmd.row   = bam_lls_pkg::ROW_W'(layer_q);
		cmd.col   = '0;
		cmd.color = in_word.pixel_color;
		cmd.layer = 3'(layer_q);
		cmd.plane = plane_q;
		case (in_word.func)
			bam_lls_pkg::FUNC_TICK: begin
				if (dwell_q == '0) begin
					cmd.op    = bam_lls_pkg::OP_SHOW;
					dwell_cur = dwell_load;
				end
				dwell_d = dwell_cur - bam_lls_pkg::DWELL_W'(1);
				if (dwell_d == '0) begin
					if (layer_q == LAST_LAYER) begin
						layer_d = '0;
						plane_d = (plane_q <= LOW_PLANE) ? bam_lls_pkg::PLANE_TOP
							: plane_q - 3'd1;
					end else begin
						layer_d = layer_q + LAYER_W'(1);
					end
				end
			end
			bam_lls_pkg::FUNC_WRITE: begin
				if (addr_ok) begin
					cmd.op   = bam_lls_pkg::OP_WRITE;
					cmd.bank = ~front_q;
					cmd.row  = wr_row;
					cmd.col  = wr_col;
				end
			end
			bam_lls_pkg::FUNC_SWAP: begin
				front_d = ~front_q;
			end
			default: begin
			end
		endcase
	end

	// scan state and scale register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_scale_q <= 8'd1;
			front_q      <= 1'b0;
			layer_q      <= '0;
			plane_q      <= bam_lls_pkg::PLANE_TOP;
			dwell_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				tick_scale_q <= cfg_wr_data;
			end
			if (accept) begin
				front_q <= front_d;
				layer_q <= layer_d;
				plane_q <= plane_d;
				dwell_q <= dwell_d;
			end
		end
	end

endmodule

>>> rtl/bam_lls_back.sv
// back end: frame store, row read, word build and output register
module bam_lls_back #(
	parameter int LAYER_COUNT    = 8,
	parameter int LEDS_PER_LAYER = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cmd_valid,
	output logic                   cmd_ready,
	input  bam_lls_pkg::cmd_t      cmd,
	output logic                   out_valid,
	input  logic                   out_ready,
	output bam_lls_pkg::out_word_t out_word
);

	localparam int LAYER_W = $clog2(LAYER_COUNT);
	localparam int RAM_AW  = LAYER_W + 1;
	localparam int DEPTH   = 2 ** RAM_AW;
	localparam int SHOWN   = (LEDS_PER_LAYER < bam_lls_pkg::MAX_SHOWN) ? LEDS_PER_LAYER
		: bam_lls_pkg::MAX_SHOWN;

	logic [RAM_AW-1:0]              ram_addr;
	logic                           pop;
	logic                           out_free;
	logic                           adv;
	logic [bam_lls_pkg::WORD_W-1:0] col_data [SHOWN];
	logic                           col_vld  [SHOWN];

	logic                           v_s2;
	logic                           start_s2;
	logic [2:0]                     layer_s2;
	logic [2:0]                     plane_s2;

	logic                           out_v_q;
	bam_lls_pkg::out_word_t         out_word_q;
	logic [bam_lls_pkg::WORD_W-1:0] shown_q;

	logic [bam_lls_pkg::WORD_W-1:0] word;
	logic [bam_lls_pkg::WORD_W-1:0] shown_next;

	assign out_free  = !out_v_q || out_ready;
	assign adv       = v_s2 && out_free;
	assign cmd_ready = !v_s2 || out_free;
	assign pop       = cmd_valid && cmd_ready;
	assign ram_addr  = {cmd.bank, cmd.row[LAYER_W-1:0]};

	// one ram per shown led column, with written flags cleared at reset
	for (genvar c = 0; c < SHOWN; c++) begin : g_col
		logic             wr_en;
		logic             rd_en;
		logic [DEPTH-1:0] written_q;
		logic             vld_s2;

		assign wr_en = pop && (cmd.op == bam_lls_pkg::OP_WRITE)
			&& (cmd.col == bam_lls_pkg::COL_W'(c));
		assign rd_en = pop && (cmd.op == bam_lls_pkg::OP_SHOW);

		bam_lls_ram #(
			.WIDTH (bam_lls_pkg::WORD_W),
			.DEPTH (DEPTH)
		) u_ram (
			.clk     (clk),
			.wr_en   (wr_en),
			.wr_addr (ram_addr),
			.wr_data (cmd.color),
			.rd_en   (rd_en),
			.rd_addr (ram_addr),
			.rd_data (col_data[c])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				written_q <= '0;
			end else if (wr_en) begin
				written_q[ram_addr] <= 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (rd_en) begin
				vld_s2 <= written_q[ram_addr];
			end
		end

		assign col_vld[c] = vld_s2;
	end

	// command stage beside the ram read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (pop) begin
			v_s2 <= 1'b1;
		end else if (out_free) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			start_s2 <= (cmd.op == bam_lls_pkg::OP_SHOW);
			layer_s2 <= cmd.layer;
			plane_s2 <= cmd.plane;
		end
	end

	// test each color byte of the row against the plane bit
	always_comb begin
		logic [bam_lls_pkg::WORD_W-1:0] pix;
		logic [7:0]                     red;
		logic [7:0]                     green;
		logic [7:0]                     blue;
		word = '0;
		for (int i = 0; i < SHOWN; i++) begin
			pix   = col_vld[i] ? col_data[i] : '0;
			red   = pix[23:16];
			green = pix[15:8];
			blue  = pix[7:0];
			word[23 - i] = red[plane_s2];
			word[15 - i] = green[plane_s2];
			word[7 - i]  = blue[plane_s2];
		end
		shown_next = start_s2 ? word : shown_q;
	end

	// output register and last shown word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			shown_q <= '0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
				shown_q <= shown_next;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_word_q.slot_start   <= start_s2;
			out_word_q.shift_word   <= shown_next;
			out_word_q.active_layer <= layer_s2;
			out_word_q.bit_plane    <= plane_s2;
		end
	end

	assign out_valid = out_v_q;
	assign out_word  = out_word_q;

endmodule
